// File: design/hgmi_pkg.sv
package hgmi_pkg;

    // Register map of the configuration channel
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER_Y      = 3'd0,
        REG_ORDER_Z      = 3'd1,
        REG_START_PLANE  = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_CENTER_Z     = 3'd4,
        REG_INV_WAIST_SQ = 3'd5
    } cfg_reg_t;

    // Internal widths: u < 32.0 in Q.24, shift count up to 46
    localparam int U_W    = 29;
    localparam int K_W    = 6;
    localparam int S2_W   = 34;
    localparam int POLY_W = 39;
    localparam int G_W    = 40;
    localparam int T_W    = 33;

    localparam logic [U_W-1:0]  Q24_ONE   = 29'h100_0000;
    localparam logic [U_W-1:0]  Q24_THREE = 29'h300_0000;
    localparam logic [31:0]     LN2_Q32   = 32'd2977044472;
    localparam logic [T_W-1:0]  T_ONE     = 33'h1_0000_0000;
    localparam logic [K_W-1:0]  K_MAX     = 6'd46;

    // floor(u * 2^8 / ln2) estimate: (u * K_RECIP) >> K_RECIP_SH, low by at most one
    localparam logic [6:0] K_RECIP    = 7'd92;
    localparam int         K_RECIP_SH = 30;

    // Series terms of exp(-r), highest order first
    localparam int EXP_TERMS = 10;

    // ceil(2^36 / n) for n = 1..10; (q * M) >> 36 is exact for 32-bit q
    localparam int RECIP_SH = 36;
    localparam logic [36:0] RECIP_MAGIC [EXP_TERMS] = '{
        (37'h10_0000_0000 + 37'd0) / 37'd1,
        (37'h10_0000_0000 + 37'd1) / 37'd2,
        (37'h10_0000_0000 + 37'd2) / 37'd3,
        (37'h10_0000_0000 + 37'd3) / 37'd4,
        (37'h10_0000_0000 + 37'd4) / 37'd5,
        (37'h10_0000_0000 + 37'd5) / 37'd6,
        (37'h10_0000_0000 + 37'd6) / 37'd7,
        (37'h10_0000_0000 + 37'd7) / 37'd8,
        (37'h10_0000_0000 + 37'd8) / 37'd9,
        (37'h10_0000_0000 + 37'd9) / 37'd10
    };

endpackage

// File: design/hermite_gauss_mode_intensity_core.sv
// Channel  Direction  Handshake             Payload
// s_       in         s_tvalid / s_tready   s_tdata: pos_x, pos_y, pos_z
// m_       out        m_tvalid / m_tready   m_tdata: intensity
// cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per clock enters while s_tready is high; each item passes through
// 31 pipeline stages, the last feeding the output register.
// The figure is set by the ten-term exp series, two stages per term (multiply,
// then divide by the term index through a reciprocal multiply).
// aresetn is synchronous: it empties the pipeline and restores register defaults.
// A stalled output parks one item in a skid register; s_tready drops only while
// that register is full, so the whole pipe holds together without losing items.
module hermite_gauss_mode_intensity_core #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // pos_x [COORD_BITS-1:0], pos_y, pos_z, zero padded to whole bytes
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]            s_tdata,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // intensity [31:0]
    output logic [31:0]                                  m_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [hgmi_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [(COORD_BITS > 32 ? COORD_BITS : 32)-1:0] cfg_data
);
    import hgmi_pkg::*;

    localparam int DN_SH   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int UP_SH   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int FAR_SH  = FRAC_BITS + 16;
    localparam int NSTG    = 31;

    // ---------------- configuration registers ----------------
    logic [1:0]            order_reg [2];
    logic [COORD_BITS-1:0] start_plane_reg;
    logic [COORD_BITS-1:0] center_reg [2];
    logic [31:0]           inv_waist_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg[0]     <= '0;
            order_reg[1]     <= '0;
            start_plane_reg  <= '0;
            center_reg[0]    <= '0;
            center_reg[1]    <= '0;
            inv_waist_sq_reg <= {3'd0, Q24_ONE};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORDER_Y:      order_reg[0]     <= cfg_data[1:0];
                REG_ORDER_Z:      order_reg[1]     <= cfg_data[1:0];
                REG_START_PLANE:  start_plane_reg  <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:     center_reg[0]    <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Z:     center_reg[1]    <= cfg_data[COORD_BITS-1:0];
                REG_INV_WAIST_SQ: inv_waist_sq_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // The pipe advances whenever the skid register is empty.
    logic            en;
    logic            v_reg [1:NSTG];
    logic            skid_valid_reg;
    logic [31:0]     skid_data_reg;
    logic            m_tvalid_reg;
    logic [31:0]     m_tdata_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- stage registers ----------------
    logic                  below_reg [1:30];
    logic [COORD_BITS-1:0] d_reg     [2];
    logic                  far_reg   [2][2:3];
    logic [63:0]           d2_reg    [2];
    logic [63:0]           ahi_reg   [2];
    logic [32:0]           alo_reg   [2];
    logic                  kill_reg  [2][4:29];
    logic [U_W-1:0]        u_reg     [2][4:5];
    logic [K_W-1:0]        ke_reg    [2][5:6];
    logic [S2_W-1:0]       s2_reg    [2];
    logic [32:0]           rpre_reg  [2];
    logic [POLY_W-1:0]     poly_reg  [2][6:27];
    logic [31:0]           r_reg     [2][7:25];
    logic [K_W-1:0]        k_reg     [2][7:29];
    logic [31:0]           q_reg     [2][EXP_TERMS];
    logic [T_W-1:0]        t_reg     [2][EXP_TERMS];
    logic [G_W-1:0]        ghi_reg   [2];
    logic [32:0]           glo_reg   [2];
    logic [G_W-1:0]        g_reg     [2];
    logic [31:0]           f_reg     [2];
    logic [63:0]           prod_reg;

    // ---------------- next values ----------------
    logic                  below_next;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos [2];
    logic [COORD_BITS:0]   dif [2];
    logic [COORD_BITS-1:0] d_next [2];
    logic [COORD_BITS+16:0] dw [2];
    logic                  far_next [2];
    logic [63:0]           d2_next [2];
    logic [63:0]           ahi_next [2];
    logic [63:0]           alo_full [2];
    logic [33:0]           asum [2];
    logic                  kill_next [2];
    logic [35:0]           kprod [2];
    logic [U_W-1:0]        tgt [2];
    logic [U_W-1:0]        s_val [2];
    logic [57:0]           s_sq [2];
    logic [S2_W-1:0]       s2_next [2];
    logic [37:0]           rdiff [2];
    logic [63:0]           p3 [2];
    logic [POLY_W-1:0]     poly_next [2];
    logic                  r_ge [2];
    logic [31:0]           r_next [2];
    logic [K_W-1:0]        k_next [2];
    logic [T_W-1:0]        t_src [2][EXP_TERMS];
    logic [64:0]           rt_prod [2][EXP_TERMS];
    logic [68:0]           qm_prod [2][EXP_TERMS];
    logic [31:0]           q_next [2][EXP_TERMS];
    logic [T_W-1:0]        t_next [2][EXP_TERMS];
    logic [G_W-1:0]        ghi_next [2];
    logic [64:0]           lo_prod [2];
    logic [G_W:0]          gs [2];
    logic [G_W:0]          rnd [2];
    logic [31:0]           f_next [2];
    logic [63:0]           prod_next;
    logic [64:0]           res_sum;
    logic [31:0]           res;

    always_comb begin
        pos_x      = s_tdata[COORD_BITS-1:0];
        pos[0]     = s_tdata[2*COORD_BITS-1:COORD_BITS];
        pos[1]     = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        below_next = $signed(pos_x) < $signed(start_plane_reg);

        for (int ax = 0; ax < 2; ax++) begin
            // stage 1: exact distance from the beam axis
            dif[ax] = {pos[ax][COORD_BITS-1], pos[ax]}
                    - {center_reg[ax][COORD_BITS-1], center_reg[ax]};
            d_next[ax] = dif[ax][COORD_BITS] ? COORD_BITS'(~dif[ax] + 1'b1)
                                             : dif[ax][COORD_BITS-1:0];

            // stage 2: bring to Q16.16 and square
            far_next[ax] = |(d_reg[ax] >> FAR_SH);
            dw[ax]       = ({17'd0, d_reg[ax]} >> DN_SH) << UP_SH;
            d2_next[ax]  = {32'd0, dw[ax][31:0]} * {32'd0, dw[ax][31:0]};

            // stage 3: scale by the waist factor, high and low halves apart
            ahi_next[ax] = {32'd0, inv_waist_sq_reg} * {32'd0, d2_reg[ax][63:32]};
            alo_full[ax] = {32'd0, inv_waist_sq_reg} * {32'd0, d2_reg[ax][31:0]};

            // stage 4: u = 2 * w * d^2, drop the axis once u reaches 32
            asum[ax]      = {5'd0, ahi_reg[ax][27:0], 1'b0} + {1'b0, alo_reg[ax]};
            kill_next[ax] = (far_reg[ax][3] && (|inv_waist_sq_reg))
                          || (|ahi_reg[ax][63:28]) || (|asum[ax][33:29]);

            // stage 5: shift count estimate and (u - c)^2 for the polynomial
            kprod[ax]   = {7'd0, u_reg[ax][4]} * {29'd0, K_RECIP};
            tgt[ax]     = (order_reg[ax] == 2'd2) ? Q24_ONE : Q24_THREE;
            s_val[ax]   = (u_reg[ax][4] >= tgt[ax]) ? u_reg[ax][4] - tgt[ax]
                                                    : tgt[ax] - u_reg[ax][4];
            s_sq[ax]    = {29'd0, s_val[ax]} * {29'd0, s_val[ax]} + 58'h80_0000;
            s2_next[ax] = s_sq[ax][57:24];

            // stage 6: remainder before correction, squared polynomial
            rdiff[ax] = {1'b0, u_reg[ax][5], 8'd0}
                      - ({32'd0, ke_reg[ax][5]} * {6'd0, LN2_Q32});
            p3[ax]    = {1'b0, {34'd0, u_reg[ax][5]} * {29'd0, s2_reg[ax]}}
                      + 64'h80_0000;
            case (order_reg[ax])
                2'd0:    poly_next[ax] = {10'd0, Q24_ONE};
                2'd1:    poly_next[ax] = {10'd0, u_reg[ax][5]};
                2'd2:    poly_next[ax] = {5'd0, s2_reg[ax]};
                default: poly_next[ax] = p3[ax][62:24];
            endcase

            // stage 7: one correction step on the reduced argument
            r_ge[ax]   = rpre_reg[ax] >= {1'b0, LN2_Q32};
            r_next[ax] = r_ge[ax] ? 32'(rpre_reg[ax] - {1'b0, LN2_Q32})
                                  : rpre_reg[ax][31:0];
            k_next[ax] = ke_reg[ax][6] + {5'd0, r_ge[ax]};

            // series of exp(-r): t = 1 - (r*t)/n, n from ten down to one
            for (int j = 0; j < EXP_TERMS; j++) begin
                t_src[ax][j]   = (j == 0) ? T_ONE : t_reg[ax][(j == 0) ? 0 : j-1];
                rt_prod[ax][j] = {33'd0, r_reg[ax][7+2*j]} * {32'd0, t_src[ax][j]};
                q_next[ax][j]  = rt_prod[ax][j][63:32];
                qm_prod[ax][j] = {37'd0, q_reg[ax][j]}
                               * {32'd0, RECIP_MAGIC[EXP_TERMS-1-j]};
                t_next[ax][j]  = T_ONE - {1'b0, qm_prod[ax][j][RECIP_SH+31:RECIP_SH]};
            end

            // stage 28: polynomial times series, split across two multipliers
            ghi_next[ax] = {33'd0, poly_reg[ax][27][POLY_W-1:32]}
                         * {7'd0, t_reg[ax][EXP_TERMS-1]};
            lo_prod[ax]  = {33'd0, poly_reg[ax][27][31:0]}
                         * {32'd0, t_reg[ax][EXP_TERMS-1]};

            // stage 30: scale by 2^-k rounding half up, cap at full scale
            gs[ax]  = {g_reg[ax], 1'b0} >> k_reg[ax][29];
            rnd[ax] = (k_reg[ax][29] == '0) ? {1'b0, g_reg[ax]} : (gs[ax] + 1'b1) >> 1;
            if (kill_reg[ax][29])
                f_next[ax] = '0;
            else if (|rnd[ax][G_W:32])
                f_next[ax] = '1;
            else
                f_next[ax] = rnd[ax][31:0];
        end

        // stage 31: combine axes
        prod_next = below_reg[30] ? 64'd0 : {32'd0, f_reg[0]} * {32'd0, f_reg[1]};

        // output: back to Q8.24, saturate
        res_sum = {1'b0, prod_reg} + 65'h80_0000;
        res     = (|res_sum[64:56]) ? '1 : res_sum[55:24];
    end

    // ---------------- pipeline ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= NSTG; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[1] <= s_tvalid;
            for (int i = 2; i <= NSTG; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            below_reg[1] <= below_next;
            for (int i = 2; i <= 30; i++) below_reg[i] <= below_reg[i-1];
            for (int ax = 0; ax < 2; ax++) begin
                d_reg[ax]        <= d_next[ax];
                far_reg[ax][2]   <= far_next[ax];
                far_reg[ax][3]   <= far_reg[ax][2];
                d2_reg[ax]       <= d2_next[ax];
                ahi_reg[ax]      <= ahi_next[ax];
                alo_reg[ax]      <= alo_full[ax][63:31];
                kill_reg[ax][4]  <= kill_next[ax];
                for (int i = 5; i <= 29; i++) kill_reg[ax][i] <= kill_reg[ax][i-1];
                u_reg[ax][4]     <= asum[ax][U_W-1:0];
                u_reg[ax][5]     <= u_reg[ax][4];
                ke_reg[ax][5]    <= kprod[ax][35:K_RECIP_SH];
                ke_reg[ax][6]    <= ke_reg[ax][5];
                s2_reg[ax]       <= s2_next[ax];
                rpre_reg[ax]     <= rdiff[ax][32:0];
                poly_reg[ax][6]  <= poly_next[ax];
                for (int i = 7; i <= 27; i++) poly_reg[ax][i] <= poly_reg[ax][i-1];
                r_reg[ax][7]     <= r_next[ax];
                for (int i = 8; i <= 25; i++) r_reg[ax][i] <= r_reg[ax][i-1];
                k_reg[ax][7]     <= k_next[ax];
                for (int i = 8; i <= 29; i++) k_reg[ax][i] <= k_reg[ax][i-1];
                for (int j = 0; j < EXP_TERMS; j++) begin
                    q_reg[ax][j] <= q_next[ax][j];
                    t_reg[ax][j] <= t_next[ax][j];
                end
                ghi_reg[ax]      <= ghi_next[ax];
                glo_reg[ax]      <= lo_prod[ax][64:32];
                g_reg[ax]        <= ghi_reg[ax] + {7'd0, glo_reg[ax]};
                f_reg[ax]        <= f_next[ax];
            end
            prod_reg <= prod_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                // drain the parked item first
                if (m_tready) begin
                    m_tdata_reg    <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (!m_tvalid_reg || m_tready) begin
                m_tvalid_reg <= v_reg[NSTG];
                m_tdata_reg  <= res;
            end else if (v_reg[NSTG]) begin
                // hold the output, park the arriving item
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res;
            end
        end
    end

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid register full while output register empty");

    a_r_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[7] |-> (r_reg[0][7] < LN2_Q32) && (r_reg[1][7] < LN2_Q32))
        else $error("exp argument not reduced below ln2");

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[7] |-> (k_reg[0][7] <= K_MAX) && (k_reg[1][7] <= K_MAX))
        else $error("exp shift count out of range");

    a_series_live: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[9] |-> (t_reg[0][0] != '0) && (t_reg[1][0] != '0))
        else $error("series term collapsed to zero");

endmodule

// File: tb/sv/hermite_gauss_mode_intensity_core_test.sv
`timescale 1ns / 1ps

module hermite_gauss_mode_intensity_core_test;
    import hgmi_pkg::*;

    localparam int  PIPE_DEPTH   = 32;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam logic [63:0] LN2_FIX = 64'd2977044472;

    logic        aclk;
    logic        aresetn;
    logic [95:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    hermite_gauss_mode_intensity_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // intensity [31:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the beam settings, mirrored on every register write
    logic [1:0]         beam_order_y;
    logic [1:0]         beam_order_z;
    logic signed [31:0] beam_plane;
    logic signed [31:0] beam_cy;
    logic signed [31:0] beam_cz;
    logic [31:0]        beam_w;

    logic [31:0] intensity_queue[$];
    int          mismatch_count;
    int          items_sent;
    int          items_checked;
    int          zero_results;
    int          settings_run;
    longint      cycle_count;
    bit          hold_off;   // long receiver stall requested by the stimulus

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Rounded Q.24 product
    function automatic logic [63:0] mul_q24(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'h80_0000) >> 24;
    endfunction

    // Gaussian envelope times squared Hermite term for one axis
    function automatic logic [63:0] axis_weight(input logic [1:0] ord,
                                                input logic signed [31:0] p,
                                                input logic signed [31:0] c);
        logic [63:0] d, d2, u, k, r, t, poly, s, g, u32;
        d = (p < c) ? 64'($signed(c)) - 64'($signed(p)) : 64'($signed(p)) - 64'($signed(c));
        if ((d >> 32) != 0) begin
            if (beam_w != 0) return 64'd0;
            u = 0;
        end else begin
            d2 = d * d;
            u = 64'(beam_w) * (d2 >> 32);
            if (u >= (64'd1 << 28)) return 64'd0;
            u = 2 * u + ((64'(beam_w) * (d2 & 64'hFFFF_FFFF)) >> 31);
            if (u >= (64'd1 << 29)) return 64'd0;
        end
        u32 = u << 8;
        k = u32 / LN2_FIX;
        r = u32 - k * LN2_FIX;
        t = 64'd1 << 32;
        for (int n = 10; n >= 1; n--)
            t = (64'd1 << 32) - ((r * t) >> 32) / 64'(n);
        case (ord)
            2'd0: poly = 64'd1 << 24;
            2'd1: poly = u;
            2'd2: begin
                s = (u >= (64'd1 << 24)) ? u - (64'd1 << 24) : (64'd1 << 24) - u;
                poly = mul_q24(s, s);
            end
            default: begin
                s = (u >= (64'd3 << 24)) ? u - (64'd3 << 24) : (64'd3 << 24) - u;
                poly = mul_q24(u, mul_q24(s, s));
            end
        endcase
        g = (poly >> 32) * t + (((poly & 64'hFFFF_FFFF) * t) >> 32);
        if (k > 0) g = (g + (64'd1 << (k - 1))) >> k;
        return (g > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : g;
    endfunction

    function automatic logic [31:0] mode_intensity(input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z);
        logic [63:0] fy, fz, res;
        if (x < beam_plane) return 32'd0;
        fy = axis_weight(beam_order_y, y, beam_cy);
        fz = axis_weight(beam_order_z, z, beam_cz);
        res = (fy * fz + 64'h80_0000) >> 24;
        return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
    endfunction

    // One register write, then cfg_valid dropped and the channel left idle before returning
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ORDER_Y:      beam_order_y = val[1:0];
            REG_ORDER_Z:      beam_order_z = val[1:0];
            REG_START_PLANE:  beam_plane   = val;
            REG_CENTER_Y:     beam_cy      = val;
            REG_CENTER_Z:     beam_cz      = val;
            REG_INV_WAIST_SQ: beam_w       = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Write to an index past the map: must change nothing
    task automatic write_unmapped(input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= 3'(REG_INV_WAIST_SQ) + 3'd1 + 3'($urandom_range(0, 1));
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Push one point; expected is forced when known at a glance.
    // tvalid stays high into the next item when no gap is drawn.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit known,
                              input logic [31:0] known_val);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        intensity_queue.push_back(known ? known_val : mode_intensity(x, y, z));
        items_sent++;
    endtask

    // Drop tvalid and wait for the pipe to drain before touching the registers
    task automatic drain;
        s_tvalid <= 1'b0;
        while (intensity_queue.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] near_coord(input logic [31:0] c);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return c + 32'($signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0000_FFFF);
            default: return c + 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (wait_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Checker: compare each delivered item against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (intensity_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected intensity item %h", m_tdata);
            end else begin
                logic [31:0] want;
                want = intensity_queue.pop_front();
                items_checked++;
                if (want == 0) zero_results++;
                if (m_tdata !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("intensity mismatch: expected %h, got %h", want, m_tdata);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[hermite_gauss_mode_intensity_core] ERROR");
            $finish;
        end
    end

    typedef struct {
        logic [31:0] x, y, z;
        bit          known;
        logic [31:0] val;
    } point_row_t;

    point_row_t directed_rows[$];

    initial begin
        logic [31:0] rnd;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_off  = 1'b0;
        mismatch_count = 0;
        items_sent = 0;
        items_checked = 0;
        zero_results = 0;
        settings_run = 0;
        cycle_count = 0;
        beam_order_y = 0;
        beam_order_z = 0;
        beam_plane = 0;
        beam_cy = 0;
        beam_cz = 0;
        beam_w = 32'h0100_0000;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows after reset: on axis gives exactly 1.0, below plane 0,
        // far from axis 0, the plane itself is evaluated
        directed_rows = '{
            '{32'h0, 32'h0, 32'h0, 1'b1, 32'h0100_0000},
            '{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0},
            '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 1'b0, 32'h0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h0},
            '{32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0},
            '{32'h0, 32'h0000_8000, 32'hFFFF_8000, 1'b0, 32'h0},
            '{32'h0, 32'h0003_0000, 32'h0000_1000, 1'b0, 32'h0}
        };
        foreach (directed_rows[i])
            send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                       directed_rows[i].known, directed_rows[i].val);
        drain();

        // Four order pairs (z order mirrors y), each at two off-axis points; a zero waist factor last
        for (int oy = 0; oy < 4; oy++) begin
            write_reg(REG_ORDER_Y, 32'(oy) | 32'hFFFF_FFFC);
            write_reg(REG_ORDER_Z, 32'(3 - oy));
            send_point(32'h10, 32'h0001_0000, 32'hFFFF_4000, 1'b0, 0);
            send_point(32'h10, 32'h0000_4000, 32'h0001_C000, 1'b0, 0);
            drain();
        end
        write_reg(REG_INV_WAIST_SQ, 32'h0);
        write_unmapped(32'hDEAD_BEEF);
        send_point(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0, 0);
        drain();

        // Random phases: new settings, then mostly points near the beam axis
        for (int phase = 0; phase < 16; phase++) begin
            write_reg(REG_ORDER_Y, $urandom);
            write_reg(REG_ORDER_Z, $urandom);
            case (phase % 4)
                0: write_reg(REG_START_PLANE, 32'h8000_0000);
                1: write_reg(REG_START_PLANE, 32'h7FFF_FFFF);
                default: write_reg(REG_START_PLANE, $urandom);
            endcase
            write_reg(REG_CENTER_Y, (phase == 1) ? 32'h7FFF_FFFF : $urandom);
            write_reg(REG_CENTER_Z, (phase == 2) ? 32'h8000_0000 : $urandom);
            case (phase % 5)
                0: rnd = 32'hFFFF_FFFF;
                1: rnd = 32'h0;
                default: rnd = $urandom_range(32'h0000_1000, 32'h0800_0000);
            endcase
            write_reg(REG_INV_WAIST_SQ, rnd);
            settings_run++;
            if (phase == 5) hold_off = 1'b1;
            for (int i = 0; i < 50; i++) begin
                logic [31:0] px;
                px = ($urandom_range(0, 7) == 0) ? $urandom
                                                : beam_plane + $urandom_range(0, 32'h0010_0000);
                if (beam_plane[31] == 1'b0 && px[31] != beam_plane[31] &&
                    $urandom_range(0, 1) == 1)
                    px = beam_plane;
                send_point(px, near_coord(beam_cy), near_coord(beam_cz), 1'b0, 0);
            end
            drain();
        end

        $display("sent %0d points, checked %0d over %0d random beam settings",
                 items_sent, items_checked, settings_run);
        $display("%0d of them zero, including below-plane and off-axis points",
                 zero_results);
        if (mismatch_count == 0 && intensity_queue.size() == 0) begin
            $display("[hermite_gauss_mode_intensity_core] OK");
        end else begin
            $display("%0d mismatches, %0d items outstanding", mismatch_count,
                     intensity_queue.size());
            $display("[hermite_gauss_mode_intensity_core] ERROR");
        end
        $finish;
    end

endmodule
